[hw/rtl/alsppm_pkg.sv]
// shared types, constants and lookup tables for the alcohol ppm converter
`timescale 1ns / 1ps
`default_nettype none
package alsppm_pkg;

	localparam int MV_W       = 12;
	localparam int CONC_W     = 15;
	localparam int ZERO_W     = 17;
	localparam int PROD_W     = MV_W + CONC_W;
	localparam int ROM_POINTS = 22;
	localparam int ROM_IDX_W  = 5;
	localparam int CNT_W      = 4;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_CAL_MIN      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CAL_MAX      = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FACTORY_ZERO = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BOOT_ZERO    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BOOT_VALID   = 3'd5;

	localparam logic [1:0] KEY_NONE  = 2'd0;
	localparam logic [1:0] KEY_SHORT = 2'd1;
	localparam logic [1:0] KEY_LONG  = 2'd2;

	localparam logic [1:0] LED_NONE    = 2'd0;
	localparam logic [1:0] LED_CAL_OK  = 2'd1;
	localparam logic [1:0] LED_FACTORY = 2'd2;

	localparam logic [2:0] ST_BELOW_ZERO  = 3'd0;
	localparam logic [2:0] ST_ABOVE_TOP   = 3'd1;
	localparam logic [2:0] ST_BELOW_FIRST = 3'd2;
	localparam logic [2:0] ST_INTERP      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

	typedef struct packed {
		logic                 found;
		logic [ROM_IDX_W-1:0] idx;
	} srch_res_t;

	function automatic logic [MV_W-1:0] volt_rom(input logic [ROM_IDX_W-1:0] i);
		logic [MV_W-1:0] r;
		case (i)
			5'd0:  r = 12'd240;
			5'd1:  r = 12'd530;
			5'd2:  r = 12'd700;
			5'd3:  r = 12'd780;
			5'd4:  r = 12'd850;
			5'd5:  r = 12'd910;
			5'd6:  r = 12'd950;
			5'd7:  r = 12'd980;
			5'd8:  r = 12'd1000;
			5'd9:  r = 12'd1030;
			5'd10: r = 12'd1050;
			5'd11: r = 12'd1080;
			5'd12: r = 12'd1120;
			5'd13: r = 12'd1150;
			5'd14: r = 12'd1180;
			5'd15: r = 12'd1200;
			5'd16: r = 12'd1230;
			5'd17: r = 12'd1300;
			5'd18: r = 12'd1330;
			5'd19: r = 12'd1350;
			5'd20: r = 12'd1400;
			5'd21: r = 12'd1450;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [CONC_W-1:0] conc_rom(input logic [ROM_IDX_W-1:0] i);
		logic [CONC_W-1:0] r;
		case (i)
			5'd0:  r = 15'd0;
			5'd1:  r = 15'd500;
			5'd2:  r = 15'd1000;
			5'd3:  r = 15'd1500;
			5'd4:  r = 15'd2000;
			5'd5:  r = 15'd2500;
			5'd6:  r = 15'd3000;
			5'd7:  r = 15'd3500;
			5'd8:  r = 15'd4000;
			5'd9:  r = 15'd4500;
			5'd10: r = 15'd5000;
			5'd11: r = 15'd6000;
			5'd12: r = 15'd7000;
			5'd13: r = 15'd8000;
			5'd14: r = 15'd9000;
			5'd15: r = 15'd10000;
			5'd16: r = 15'd12000;
			5'd17: r = 15'd15000;
			5'd18: r = 15'd16000;
			5'd19: r = 15'd20000;
			5'd20: r = 15'd25000;
			5'd21: r = 15'd30000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/alsppm_search.sv]
// sequential span search over the voltage table, one span per cycle
`timescale 1ns / 1ps
`default_nettype none
module alsppm_search
	import alsppm_pkg::*;
#(
	parameter int NPTS = 22
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [MV_W-1:0] v,
	output logic                 done,
	output srch_res_t            res
);

	localparam int IDX_W = (NPTS > 2) ? $clog2(NPTS) : 1;
	localparam logic [IDX_W-1:0] LAST_SPAN = IDX_W'(NPTS - 2);

	logic             busy_q;
	logic             done_q;
	logic [IDX_W-1:0] idx_q;
	srch_res_t        res_q;
	logic [MV_W-1:0]  lo, hi;
	logic             hit;

	assign lo  = volt_rom(ROM_IDX_W'(idx_q));
	assign hi  = volt_rom(ROM_IDX_W'(idx_q) + ROM_IDX_W'(1));
	assign hit = (v >= lo) && (v <= hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (hit || idx_q == LAST_SPAN) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			res_q.found <= hit;
			res_q.idx   <= ROM_IDX_W'(idx_q);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

[hw/rtl/alsppm_muldiv.sv]
// bit-serial shift-add multiply followed by restoring divide
`timescale 1ns / 1ps
`default_nettype none
module alsppm_muldiv
	import alsppm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CONC_W-1:0] mcand,
	input  wire logic [MV_W-1:0]   mplier,
	input  wire logic [MV_W-1:0]   divisor,
	output logic                   done,
	output logic [CONC_W-1:0]      quo
);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_PREP = 4'b0100,
		M_DIV  = 4'b1000
	} md_state_t;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MV_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CONC_W - 1);

	md_state_t         state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MV_W-1:0]   mplr_q;
	logic [PROD_W-1:0] acc_q;
	logic [MV_W-1:0]   dvsr_q;
	logic [MV_W-1:0]   rem_q;
	logic [CONC_W-1:0] low_q;
	logic [CONC_W-1:0] quo_q;
	logic [MV_W:0]     trial;
	logic              qbit;

	assign trial = {rem_q, low_q[CONC_W-1]};
	assign qbit  = (trial >= {1'b0, dvsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						cnt_q   <= '0;
					end
				end
				M_MUL: begin
					if (cnt_q == MUL_LAST) begin
						state_q <= M_PREP;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				M_PREP: begin
					state_q <= M_DIV;
					cnt_q   <= '0;
				end
				M_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			mcand_q <= PROD_W'(mcand);
			mplr_q  <= mplier;
			dvsr_q  <= divisor;
			acc_q   <= '0;
		end
		if (state_q == M_MUL) begin
			if (mplr_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
			mplr_q  <= {1'b0, mplr_q[MV_W-1:1]};
		end
		if (state_q == M_PREP) begin
			rem_q <= acc_q[PROD_W-1:CONC_W];
			low_q <= acc_q[CONC_W-1:0];
		end
		if (state_q == M_DIV) begin
			rem_q <= qbit ? MV_W'(trial - {1'b0, dvsr_q}) : trial[MV_W-1:0];
			low_q <= {low_q[CONC_W-2:0], 1'b0};
			quo_q <= {quo_q[CONC_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

[hw/rtl/alcohol_sensor_ppm_lookup.sv]
// top level of the sensor voltage to alcohol concentration converter
//
// usage: one item per transfer on the s_ channel carries a key event, a
// calibration sample and the sensor voltage; one result per item leaves on
// the m_ channel. configuration registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them while the block is idle,
// which the block itself does not enforce. readings that clamp (at or below
// zero, at or above the top point, below the first point) go straight to the
// output register once it is free. readings that interpolate search the table
// one span per cycle, then pass through the multiply, a setup step and the
// divide, one bit per step, before the output register. the block takes one
// item at a time; s_tready is high only while no item is in work, so the next
// item can be taken in the cycle after a result enters the output register,
// even while that result still waits there.
// reset: the control state and configuration registers return to their
// defaults, the zero voltage is 240 mV and the output register is empty; the
// result payload registers are not reset. when the receiver stalls, the result
// is held in the output register and a finished next result waits in the block.
`timescale 1ns / 1ps
`default_nettype none
module alcohol_sensor_ppm_lookup
	import alsppm_pkg::*;
#(
	parameter int TABLE_POINTS = 22
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,  // key_event, cal_sample_mv, sample_mv
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [39:0]                m_tdata,  // concentration_cppm, range_status,
	                                             // save_request, saved_zero_mv, led_code
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int NPTS = (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS :
	                      ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
	localparam logic [MV_W-1:0]   V_TOP = volt_rom(ROM_IDX_W'(NPTS - 1));
	localparam logic [CONC_W-1:0] C_TOP = conc_rom(ROM_IDX_W'(NPTS - 1));
	localparam logic [MV_W-1:0]   V_FIRST = volt_rom(ROM_IDX_W'(0));
	localparam logic [CONC_W-1:0] C_FIRST = conc_rom(ROM_IDX_W'(0));

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SRCH = 4'b0010,
		S_MDIV = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [MV_W-1:0]     cal_min_q, cal_max_q, factory_zero_q;
	logic [7:0]          offset_q;
	logic [15:0]         boot_zero_q;
	logic                boot_valid_q;
	logic [ZERO_W-1:0]   zero_q;

	logic [MV_W-1:0]     v_q;
	logic [CONC_W-1:0]   conc_q;
	logic [CONC_W-1:0]   base_q;
	logic [2:0]          status_q;
	logic                save_q;
	logic [MV_W-1:0]     saved_q;
	logic [1:0]          led_q;

	logic                out_valid_q;
	logic [39:0]         out_data_q;

	logic [1:0]          in_key;
	logic [MV_W-1:0]     in_cal, in_v;
	logic                accept;
	logic                cal_ok;

	logic                srch_start, srch_done;
	srch_res_t           srch_res;
	logic [MV_W-1:0]     span_lo, span_hi;
	logic [CONC_W-1:0]   span_c0, span_c1;
	logic                md_start, md_done, md_skip;
	logic [CONC_W-1:0]   md_quo;
	logic                out_free;

	assign in_key   = s_tdata[1:0];
	assign in_cal   = s_tdata[13:2];
	assign in_v     = s_tdata[25:14];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cal_ok   = (in_cal >= cal_min_q) && (in_cal <= cal_max_q);
	assign out_free = !out_valid_q || m_tready;

	assign span_lo = volt_rom(srch_res.idx);
	assign span_hi = volt_rom(srch_res.idx + ROM_IDX_W'(1));
	assign span_c0 = conc_rom(srch_res.idx);
	assign span_c1 = conc_rom(srch_res.idx + ROM_IDX_W'(1));
	assign md_skip = (span_hi == span_lo) || (span_c1 < span_c0);

	assign srch_start = accept && ({5'd0, in_v} > zero_q) && (in_v < V_TOP)
	                    && (in_v >= V_FIRST);
	assign md_start   = (state_q == S_SRCH) && srch_done && srch_res.found && !md_skip;

	alsppm_search #(
		.NPTS(NPTS)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (srch_start),
		.v     (v_q),
		.done  (srch_done),
		.res   (srch_res)
	);

	alsppm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.mcand  (span_c1 - span_c0),
		.mplier (v_q - span_lo),
		.divisor(span_hi - span_lo),
		.done   (md_done),
		.quo    (md_quo)
	);

	// configuration registers and zero voltage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q      <= 12'd100;
			cal_max_q      <= 12'd500;
			offset_q       <= 8'd10;
			factory_zero_q <= 12'd240;
			boot_zero_q    <= 16'd0;
			boot_valid_q   <= 1'b0;
			zero_q         <= 17'd240;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_CAL_MIN:      cal_min_q <= cfg_wdata[MV_W-1:0];
					REG_CAL_MAX:      cal_max_q <= cfg_wdata[MV_W-1:0];
					REG_ZERO_OFFSET:  offset_q <= cfg_wdata[7:0];
					REG_FACTORY_ZERO: factory_zero_q <= cfg_wdata[MV_W-1:0];
					REG_BOOT_ZERO:    boot_zero_q <= cfg_wdata;
					REG_BOOT_VALID: begin
						boot_valid_q <= cfg_wdata[0];
						if (cfg_wdata[0]) begin
							zero_q <= {1'b0, boot_zero_q} + {9'd0, offset_q};
						end
					end
					default: ;
				endcase
			end else if (accept) begin
				if (in_key == KEY_SHORT && cal_ok) begin
					zero_q <= {5'd0, in_cal} + {9'd0, offset_q};
				end else if (in_key == KEY_LONG) begin
					zero_q <= {5'd0, factory_zero_q};
				end
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= srch_start ? S_SRCH : S_OUT;
					end
				end
				S_SRCH: begin
					if (srch_done) begin
						state_q <= md_start ? S_MDIV : S_OUT;
					end
				end
				S_MDIV: begin
					if (md_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= in_v;
			save_q  <= 1'b0;
			saved_q <= '0;
			led_q   <= LED_NONE;
			if (in_key == KEY_SHORT && cal_ok) begin
				save_q  <= 1'b1;
				saved_q <= in_cal;
				led_q   <= LED_CAL_OK;
			end else if (in_key == KEY_LONG) begin
				save_q  <= 1'b1;
				saved_q <= factory_zero_q;
				led_q   <= LED_FACTORY;
			end
			if ({5'd0, in_v} <= zero_q) begin
				conc_q   <= C_FIRST;
				status_q <= ST_BELOW_ZERO;
			end else if (in_v >= V_TOP) begin
				conc_q   <= C_TOP;
				status_q <= ST_ABOVE_TOP;
			end else begin
				conc_q   <= '0;
				status_q <= ST_BELOW_FIRST;
			end
		end
		if (state_q == S_SRCH && srch_done) begin
			base_q <= span_c0;
			if (!srch_res.found) begin
				conc_q   <= C_TOP;
				status_q <= ST_NOT_FOUND;
			end else begin
				conc_q   <= span_c0;
				status_q <= ST_INTERP;
			end
		end
		if (state_q == S_MDIV && md_done) begin
			conc_q <= base_q + md_quo;
		end
		if (state_q == S_OUT && out_free) begin
			out_data_q <= {7'd0, led_q, saved_q, save_q, status_q, conc_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the alcohol ppm converter: directed table, then random phases
`timescale 1ns / 1ps
module tb_top
	import alsppm_pkg::*;
();

	localparam int TABLE_POINTS = 22;
	localparam int USED_POINTS  = (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS :
	                              (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int NPROBE       = 23;
	localparam logic [1:0] KEY_UNUSED = 2'd3;

	localparam logic [0:21][11:0] VOLT_PTS = '{
		12'd240, 12'd530, 12'd700, 12'd780, 12'd850, 12'd910, 12'd950, 12'd980,
		12'd1000, 12'd1030, 12'd1050, 12'd1080, 12'd1120, 12'd1150, 12'd1180,
		12'd1200, 12'd1230, 12'd1300, 12'd1330, 12'd1350, 12'd1400, 12'd1450};
	localparam logic [0:21][14:0] CONC_PTS = '{
		15'd0, 15'd500, 15'd1000, 15'd1500, 15'd2000, 15'd2500, 15'd3000, 15'd3500,
		15'd4000, 15'd4500, 15'd5000, 15'd6000, 15'd7000, 15'd8000, 15'd9000,
		15'd10000, 15'd12000, 15'd15000, 15'd16000, 15'd20000, 15'd25000, 15'd30000};

	// register sets, in register index order
	localparam logic [0:3][0:5][15:0] CFG_SETS = '{
		'{16'd100, 16'd500, 16'd10, 16'd240, 16'd0, 16'd0},
		'{16'd0, 16'd4095, 16'd255, 16'd0, 16'd65535, 16'd1},
		'{16'd3300, 16'd3300, 16'd0, 16'd4095, 16'd0, 16'd1},
		'{16'd500, 16'd100, 16'd128, 16'd1000, 16'd1200, 16'd1}};

	typedef struct packed {
		logic [1:0]  led;
		logic [11:0] saved;
		logic        save;
		logic [2:0]  status;
		logic [14:0] conc;
	} ppm_result_t;

	typedef struct packed {
		logic [1:0]  key;
		logic [11:0] cal;
		logic [11:0] mv;
		logic        typed;
		logic [14:0] conc;
		logic [2:0]  status;
		logic        save;
		logic [11:0] saved;
		logic [1:0]  led;
	} probe_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;  // key_event, cal_sample_mv, sample_mv
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;       // concentration_cppm, range_status,
	                                      // save_request, saved_zero_mv, led_code
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor copy of the block's registers and zero
	logic [11:0] cal_lo = 12'd100;
	logic [11:0] cal_hi = 12'd500;
	logic [7:0]  offset_mv = 8'd10;
	logic [11:0] factory_mv = 12'd240;
	logic [15:0] boot_mv = 16'd0;
	logic        boot_ok = 1'b0;
	logic [16:0] zero_mv = 17'd240;

	ppm_result_t expected_readings[$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          sender_idle_pct = 0;
	int          stall_pct = 0;
	probe_t      probes [0:NPROBE-1];

	alcohol_sensor_ppm_lookup #(
		.TABLE_POINTS(TABLE_POINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic ppm_result_t convert_reading(input logic [1:0] key,
			input logic [11:0] cal, input logic [11:0] mv);
		ppm_result_t r;
		logic [16:0] zero_before;
		int unsigned lo, hi, c0, c1;
		zero_before = zero_mv;
		r = '0;
		if (key == KEY_SHORT) begin
			if (cal >= cal_lo && cal <= cal_hi) begin
				zero_mv = 17'(cal) + 17'(offset_mv);
				r.save = 1'b1;
				r.saved = cal;
				r.led = LED_CAL_OK;
			end
		end else if (key == KEY_LONG) begin
			zero_mv = 17'(factory_mv);
			r.save = 1'b1;
			r.saved = factory_mv;
			r.led = LED_FACTORY;
		end
		if (17'(mv) <= zero_before) begin
			r.conc = CONC_PTS[0];
			r.status = ST_BELOW_ZERO;
		end else if (mv >= VOLT_PTS[USED_POINTS-1]) begin
			r.conc = CONC_PTS[USED_POINTS-1];
			r.status = ST_ABOVE_TOP;
		end else if (mv < VOLT_PTS[0]) begin
			r.conc = '0;
			r.status = ST_BELOW_FIRST;
		end else begin
			r.conc = CONC_PTS[USED_POINTS-1];
			r.status = ST_NOT_FOUND;
			for (int i = 0; i < USED_POINTS - 1; i++) begin
				if (r.status == ST_NOT_FOUND && mv >= VOLT_PTS[i] &&
						mv <= VOLT_PTS[i+1]) begin
					lo = VOLT_PTS[i];
					hi = VOLT_PTS[i+1];
					c0 = CONC_PTS[i];
					c1 = CONC_PTS[i+1];
					if (hi != lo && c1 >= c0)
						r.conc = 15'(c0 + ((mv - lo) * (c1 - c0)) / (hi - lo));
					else
						r.conc = 15'(c0);
					r.status = ST_INTERP;
				end
			end
		end
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_reading(input logic [1:0] key, input logic [11:0] cal,
			input logic [11:0] mv, input logic typed, input ppm_result_t want);
		ppm_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'd0, mv, cal, key};
		do @(posedge clk); while (!s_tready);
		predicted = convert_reading(key, cal, mv);
		expected_readings.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = val;
		@(posedge clk);
		case (addr)
			REG_CAL_MIN:      cal_lo = val[11:0];
			REG_CAL_MAX:      cal_hi = val[11:0];
			REG_ZERO_OFFSET:  offset_mv = val[7:0];
			REG_FACTORY_ZERO: factory_mv = val[11:0];
			REG_BOOT_ZERO:    boot_mv = val;
			REG_BOOT_VALID: begin
				boot_ok = val[0];
				if (val[0])
					zero_mv = 17'(boot_mv) + 17'(offset_mv);
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_readings.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		ppm_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[32:0];
			if (expected_readings.size() == 0) begin
				fail_count <= fail_count + 1;
				if (fail_count < 10)
					$display("unexpected result transfer: %h", m_tdata);
			end else begin
				want = expected_readings.pop_front();
				if (got.conc !== want.conc || got.status !== want.status ||
						got.save !== want.save || got.saved !== want.saved ||
						got.led !== want.led) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display({"mismatch: conc %0d/%0d status %0d/%0d save %0d/%0d",
							" saved %0d/%0d led %0d/%0d (exp/got)"},
							want.conc, got.conc, want.status, got.status,
							want.save, got.save, want.saved, got.saved,
							want.led, got.led);
				end
			end
		end
	end

	initial begin
		logic [1:0]  key;
		logic [11:0] cal, mv;
		int          r, set;
		ppm_result_t want;

		probes = '{
			'{KEY_NONE, 12'd0, 12'd0, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd4095, 12'd240, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd241, 1'b1, 15'd1, ST_INTERP, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd530, 1'b1, 15'd500, ST_INTERP, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd1450, 1'b1, 15'd30000, ST_ABOVE_TOP, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd4095, 12'd4095, 1'b1, 15'd30000, ST_ABOVE_TOP, 1'b0, 12'd0,
				LED_NONE},
			'{KEY_NONE, 12'd0, 12'd1449, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd1000, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd1240, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_SHORT, 12'd100, 12'd700, 1'b1, 15'd1000, ST_INTERP, 1'b1, 12'd100,
				LED_CAL_OK},
			'{KEY_NONE, 12'd0, 12'd200, 1'b1, 15'd0, ST_BELOW_FIRST, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd110, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_SHORT, 12'd99, 12'd111, 1'b1, 15'd0, ST_BELOW_FIRST, 1'b0, 12'd0, LED_NONE},
			'{KEY_SHORT, 12'd500, 12'd800, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_SHORT, 12'd501, 12'd510, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_LONG, 12'd4095, 12'd511, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_UNUSED, 12'd300, 12'd241, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd2730, 12'd2730, 1'b1, 15'd30000, ST_ABOVE_TOP, 1'b0, 12'd0,
				LED_NONE},
			'{KEY_NONE, 12'd1365, 12'd1365, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_SHORT, 12'd1365, 12'd700, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_LONG, 12'd2730, 12'd239, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b1, 12'd240,
				LED_FACTORY},
			'{KEY_SHORT, 12'd250, 12'd245, 1'b0, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE},
			'{KEY_NONE, 12'd0, 12'd255, 1'b1, 15'd0, ST_BELOW_ZERO, 1'b0, 12'd0, LED_NONE}};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < NPROBE; i++) begin
			want = '{led: probes[i].led, saved: probes[i].saved, save: probes[i].save,
				status: probes[i].status, conc: probes[i].conc};
			send_reading(probes[i].key, probes[i].cal, probes[i].mv, probes[i].typed, want);
		end

		for (int p = 0; p < PHASES; p++) begin
			s_tvalid = 1'b0;
			wait_drained();
			set = (p + p / 4) % 4;
			for (int a = REG_CAL_MIN; a <= REG_BOOT_VALID; a++)
				write_reg(a[CFG_ADDR_W-1:0], CFG_SETS[set][a]);
			cfg_we = 1'b0;
			case (p % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 75; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 75; end
				default: begin sender_idle_pct = 8; stall_pct = 8; end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				key = (r < 80) ? KEY_NONE : (r < 90) ? KEY_SHORT :
				      (r < 96) ? KEY_LONG : KEY_UNUSED;

				r = $urandom_range(99);
				if (r < 50 && cal_lo <= cal_hi)
					cal = 12'($urandom_range(cal_hi, cal_lo));
				else if (r < 65) begin
					case ($urandom_range(3))
						0: cal = cal_lo - 12'd1;
						1: cal = cal_lo;
						2: cal = cal_hi;
						default: cal = cal_hi + 12'd1;
					endcase
				end else
					cal = 12'($urandom_range(4095));

				r = $urandom_range(99);
				if (r < 55)
					mv = 12'($urandom_range(1500, 200));
				else if (r < 70)
					mv = VOLT_PTS[$urandom_range(USED_POINTS - 1)] +
					     12'($urandom_range(2)) - 12'd1;
				else if (r < 80)
					mv = zero_mv[11:0] + 12'($urandom_range(2)) - 12'd1;
				else
					mv = 12'($urandom_range(4095));

				send_reading(key, cal, mv, 1'b0, '0);
			end
		end

		s_tvalid = 1'b0;
		sender_idle_pct = 0;
		stall_pct = 0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
